// ----- rtl/core/lfl_pkg.sv -----
// shared types and constants for the lazy free-list slot allocator
package lfl_pkg;

   localparam int SLOTS    = 1024;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int HANDLE_W = 31;

   typedef enum logic {
      KIND_OPEN  = 1'b0,
      KIND_CLOSE = 1'b1
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [HANDLE_W-1:0]   handle;
      logic [SLOT_W-1:0]     slot_in;
   } req_word_type;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_W-1:0]     slot_out;
      logic                  fresh;
      logic [HANDLE_W-1:0]   handle_out;
      logic [CNT_W-1:0]      free_left;
   } rsp_word_type;

endpackage

// ----- rtl/core/lazy_free_list_slot_allocator.sv -----
// lazy free-list slot allocator top level
// result word is registered on leaving the execute state, once the output register is free
// a new request word is taken only in the idle state; the execute state covers the synchronous memory read
// a waiting result does not block acceptance; the next word waits only for the output register
// reset: synchronous; slot_limit returns to 1024, free count to slot_limit, head and mark to 0
// link and handle memories are not cleared and need no clearing pass
module lazy_free_list_slot_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  lfl_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lfl_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lfl_pkg::CNT_W-1:0]    csr_data
);

   import lfl_pkg::*;

   state_type            state_ff, state_in;
   req_word_type         item_ff;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]     mark_ff, mark_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                 accept;
   logic                 commit;
   logic                 csr_write;
   logic [CNT_W-1:0]     csr_sat;
   logic [CNT_W-1:0]     slot_ext;
   logic [CNT_W-1:0]     free_dec;

   logic                 link_wr_en;
   logic [SLOT_W-1:0]    link_wr_addr;
   logic [CNT_W-1:0]     link_wr_data;
   logic [CNT_W-1:0]     link_rd_data;
   logic                 hdl_wr_en;
   logic [HANDLE_W-1:0]  hdl_rd_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign slot_ext  = {1'b0, item_ff.slot_in};
   assign free_dec  = free_ff - CNT_W'(1);

   always_comb begin
      if (csr_data == '0) begin
         csr_sat = CNT_W'(1);
      end else if (csr_data > CNT_W'(SLOTS)) begin
         csr_sat = CNT_W'(SLOTS);
      end else begin
         csr_sat = csr_data;
      end
   end

   lfl_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (accept),
      .rd_addr (head_ff[SLOT_W-1:0]),
      .rd_data (link_rd_data)
   );

   lfl_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOTS)) u_handle_ram (
      .clock   (clock),
      .wr_en   (hdl_wr_en),
      .wr_addr (head_ff[SLOT_W-1:0]),
      .wr_data (item_ff.handle),
      .rd_en   (accept),
      .rd_addr (req_word.slot_in),
      .rd_data (hdl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= CNT_W'(SLOTS);
         head_ff      <= '0;
         free_ff      <= CNT_W'(SLOTS);
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_word;
      end
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      mark_in      = mark_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      commit       = 1'b0;
      link_wr_en   = 1'b0;
      link_wr_addr = item_ff.slot_in;
      link_wr_data = head_ff;
      hdl_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            commit = !rsp_valid_ff || !rsp_stall;
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_word_in  = '0;
               if (item_ff.kind == KIND_OPEN) begin
                  if (free_ff != '0 && head_ff < limit_ff) begin
                     rsp_word_in.ok         = 1'b1;
                     rsp_word_in.slot_out   = head_ff[SLOT_W-1:0];
                     rsp_word_in.handle_out = item_ff.handle;
                     rsp_word_in.free_left  = free_dec;
                     hdl_wr_en              = 1'b1;
                     free_in                = free_dec;
                     if (head_ff == mark_ff) begin
                        rsp_word_in.fresh = 1'b1;
                        link_wr_en        = 1'b1;
                        link_wr_addr      = head_ff[SLOT_W-1:0];
                        link_wr_data      = head_ff + CNT_W'(1);
                        mark_in           = mark_ff + CNT_W'(1);
                        head_in           = head_ff + CNT_W'(1);
                     end else begin
                        head_in = link_rd_data;
                     end
                     if (free_dec == '0) begin
                        head_in = limit_ff;
                     end
                  end else begin
                     rsp_word_in.free_left = free_ff;
                  end
               end else begin
                  rsp_word_in.slot_out  = item_ff.slot_in;
                  rsp_word_in.free_left = free_ff;
                  if (slot_ext < mark_ff && free_ff < limit_ff) begin
                     rsp_word_in.ok         = 1'b1;
                     rsp_word_in.handle_out = hdl_rd_data;
                     rsp_word_in.free_left  = free_ff + CNT_W'(1);
                     link_wr_en             = 1'b1;
                     head_in                = slot_ext;
                     free_in                = free_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         limit_in = csr_sat;
         free_in  = csr_sat;
         head_in  = '0;
         mark_in  = '0;
      end
   end

endmodule

// ----- rtl/core/lfl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module lfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lfl_checker.sv -----
// port-level checks for the slot allocator and their binding
module lfl_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  lfl_pkg::rsp_word_type        rsp_word
);

   import lfl_pkg::*;

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // a fresh slot is only reported on a grant
   a_fresh_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.fresh |-> rsp_word.ok)
      else $error("fresh flag without grant");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.free_left <= CNT_W'(SLOTS))
      else $error("free count above slot count");

   // one word in flight at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

endmodule

bind lazy_free_list_slot_allocator lfl_checker u_lfl_checker (.*);
